// ===== design/allan_variance_six_axis_assert.svh =====
// assertion macros used by the checker file av6_chk.sv
// depends on nothing; each user supplies i_clk and i_rst_n in scope
`ifndef ALLAN_VARIANCE_SIX_AXIS_ASSERT_SVH
`define ALLAN_VARIANCE_SIX_AXIS_ASSERT_SVH

// implication checked in the next cycle, masked during reset
`define AV6_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// implication checked in the next cycle, also during reset
`define AV6_NEXT_ALWAYS(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== design/av6_pkg.sv =====
// shared types and constants of the six-axis allan variance block
// no dependencies
`timescale 1ns / 1ps

package av6_pkg;

    localparam int AXES       = 6;
    localparam int VAR_W      = 48;
    localparam int FRAC_BITS  = 16;
    localparam int ACC_W      = 64;
    localparam int CFG_W      = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int NUM_W      = ACC_W + FRAC_BITS;
    localparam int STEP_W     = 7;

    localparam logic [CFG_IDX_W-1:0] REG_SAMPLES   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVALS = 1'b1;

    localparam logic [CFG_W-1:0] SAMPLES_RESET   = 11'd100;
    localparam logic [CFG_W-1:0] INTERVALS_RESET = 11'd10;

    // per-lane control from the sequencer
    typedef struct packed {
        logic clear;
        logic add;
        logic close;
        logic first;
        logic div_start;
        logic div_step;
    } t_lane_ctl;

    // per-lane findings handed to the merge stage
    typedef struct packed {
        logic [VAR_W-1:0] quo;
        logic             qovf;
        logic             asat;
    } t_lane_res;

endpackage

// ===== design/av6_if.sv =====
// handshake channels: sample beats in, variance results out
// depends on av6_pkg
`timescale 1ns / 1ps

interface av6_smp_if #(
    parameter int W = 16
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] accel_x;
    logic signed [W-1:0] accel_y;
    logic signed [W-1:0] accel_z;
    logic signed [W-1:0] gyro_x;
    logic signed [W-1:0] gyro_y;
    logic signed [W-1:0] gyro_z;

    modport source (output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                    input ready);
    modport sink (input valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                  output ready);
endinterface

interface av6_res_if;
    logic                        valid;
    logic                        ready;
    logic [av6_pkg::VAR_W-1:0]   accel_x_variance;
    logic [av6_pkg::VAR_W-1:0]   accel_y_variance;
    logic [av6_pkg::VAR_W-1:0]   accel_z_variance;
    logic [av6_pkg::VAR_W-1:0]   gyro_x_variance;
    logic [av6_pkg::VAR_W-1:0]   gyro_y_variance;
    logic [av6_pkg::VAR_W-1:0]   gyro_z_variance;
    logic                        saturated;

    modport source (output valid, accel_x_variance, accel_y_variance, accel_z_variance,
                    gyro_x_variance, gyro_y_variance, gyro_z_variance, saturated,
                    input ready);
    modport sink (input valid, accel_x_variance, accel_y_variance, accel_z_variance,
                  gyro_x_variance, gyro_y_variance, gyro_z_variance, saturated,
                  output ready);
endinterface

// ===== design/av6_lane.sv =====
// one axis: interval sum, squared difference, saturating accumulator,
// bit-serial divider; depends on av6_pkg
`timescale 1ns / 1ps

module av6_lane #(
    parameter int SAMPLE_BITS = 16,
    parameter int SUM_W       = 27,
    parameter int D_W         = 37
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  av6_pkg::t_lane_ctl            i_ctl,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic [D_W-1:0]                i_den,
    output av6_pkg::t_lane_res            o_res
);

    localparam int DIF_W = SUM_W + 1;

    logic signed [SUM_W-1:0]           r_sum;
    logic signed [SUM_W-1:0]           r_prior;
    logic signed [DIF_W-1:0]           r_diff;
    logic                              r_dv;
    logic [av6_pkg::ACC_W-1:0]         r_sq;
    logic                              r_sqv;
    logic                              r_sqsat;
    logic [av6_pkg::ACC_W-1:0]         r_acc;
    logic                              r_asat;
    logic [av6_pkg::NUM_W-1:0]         r_num;
    logic [D_W-1:0]                    r_rem;
    logic [av6_pkg::VAR_W-1:0]         r_quo;
    logic                              r_qovf;

    logic signed [SUM_W-1:0]           n_sum;
    logic [DIF_W-1:0]                  mag;
    logic [av6_pkg::ACC_W-1:0]         mag64;
    logic                              mag_ovf;
    logic [av6_pkg::ACC_W:0]           acc_sum;
    logic [D_W:0]                      trial;
    logic                              ge;

    always_comb begin
        n_sum   = r_sum + SUM_W'(i_sample);
        mag     = r_diff[DIF_W-1] ? DIF_W'(-r_diff) : DIF_W'(r_diff);
        mag64   = av6_pkg::ACC_W'(mag);
        mag_ovf = |mag64[av6_pkg::ACC_W-1:32];
        acc_sum = {1'b0, r_acc} + {1'b0, r_sq};
        trial   = {r_rem, r_num[av6_pkg::NUM_W-1]};
        ge      = trial >= {1'b0, i_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_sum   <= '0;
            r_prior <= '0;
            r_dv    <= 1'b0;
            r_sqv   <= 1'b0;
            r_acc   <= '0;
            r_asat  <= 1'b0;
        end else begin
            r_dv <= 1'b0;
            if (i_ctl.add) begin
                if (i_ctl.close) begin
                    r_sum   <= '0;
                    r_prior <= n_sum;
                    r_diff  <= DIF_W'(n_sum) - DIF_W'(r_prior);
                    r_dv    <= !i_ctl.first;
                end else begin
                    r_sum <= n_sum;
                end
            end
            // square stage
            r_sqv   <= r_dv;
            r_sqsat <= mag_ovf;
            r_sq    <= mag_ovf ? '1 : mag64[31:0] * mag64[31:0];
            // accumulate stage
            if (r_sqv) begin
                if (acc_sum[av6_pkg::ACC_W]) begin
                    r_acc  <= '1;
                    r_asat <= 1'b1;
                end else begin
                    r_acc <= acc_sum[av6_pkg::ACC_W-1:0];
                end
                if (r_sqsat) begin
                    r_asat <= 1'b1;
                end
            end
        end
    end

    // restoring division of acc * 2^16 by the denominator, one bit a cycle
    always_ff @(posedge i_clk) begin
        if (i_ctl.div_start) begin
            r_num  <= {r_acc, av6_pkg::FRAC_BITS'(0)};
            r_rem  <= '0;
            r_quo  <= '0;
            r_qovf <= 1'b0;
        end else if (i_ctl.div_step) begin
            r_num  <= {r_num[av6_pkg::NUM_W-2:0], 1'b0};
            r_rem  <= ge ? D_W'(trial - {1'b0, i_den}) : trial[D_W-1:0];
            r_quo  <= {r_quo[av6_pkg::VAR_W-2:0], ge};
            r_qovf <= r_qovf | r_quo[av6_pkg::VAR_W-1];
        end
    end

    assign o_res.quo  = r_quo;
    assign o_res.qovf = r_qovf;
    assign o_res.asat = r_asat;

endmodule

// ===== design/av6_merge.sv =====
// merges the lane quotients and flags into the result register
// depends on av6_pkg and av6_res_if
`timescale 1ns / 1ps

module av6_merge (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  av6_pkg::t_lane_res   i_lane [av6_pkg::AXES],
    output logic                 o_free,
    av6_res_if.source            o_res
);

    logic                        r_valid;
    logic [av6_pkg::VAR_W-1:0]   r_var [av6_pkg::AXES];
    logic                        r_sat;
    logic                        any_sat;

    always_comb begin
        any_sat = 1'b0;
        for (int a = 0; a < av6_pkg::AXES; a++) begin
            any_sat = any_sat | i_lane[a].qovf | i_lane[a].asat;
        end
    end

    assign o_free = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load && o_free) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_free) begin
            for (int a = 0; a < av6_pkg::AXES; a++) begin
                r_var[a] <= i_lane[a].qovf ? '1 : i_lane[a].quo;
            end
            r_sat <= any_sat;
        end
    end

    assign o_res.valid            = r_valid;
    assign o_res.accel_x_variance = r_var[0];
    assign o_res.accel_y_variance = r_var[1];
    assign o_res.accel_z_variance = r_var[2];
    assign o_res.gyro_x_variance  = r_var[3];
    assign o_res.gyro_y_variance  = r_var[4];
    assign o_res.gyro_z_variance  = r_var[5];
    assign o_res.saturated        = r_sat;

endmodule

// ===== design/allan_variance_six_axis.sv =====
// Non-overlapping Allan variance over six IMU axes. One sample beat is taken per cycle
// while a run is collecting; each axis runs in its own lane (interval sum, squared
// difference, 64-bit saturating accumulator, divider). After the last beat of the
// last interval the block stops taking beats while it sets up the denominator, loads
// the divider, runs the bit-serial divider and loads the result once the output
// register is free; the result waits in that output register. A configuration write
// restarts the run.
`timescale 1ns / 1ps

module allan_variance_six_axis #(
    parameter int MAX_SAMPLES_PER_INTERVAL = 1024,
    parameter int MAX_INTERVALS            = 1024,
    parameter int SAMPLE_BITS              = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [av6_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [av6_pkg::CFG_W-1:0]       i_cfg_data,
    av6_smp_if.sink                         i_smp,
    av6_res_if.source                       o_res
);

    localparam int NB    = $clog2(MAX_SAMPLES_PER_INTERVAL + 1);
    localparam int MB    = $clog2(MAX_INTERVALS + 1);
    localparam int SUM_W = SAMPLE_BITS + NB;
    localparam int D_W   = 2 * NB + MB + 1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL1  = 3'd1;
    localparam logic [2:0] ST_MUL2  = 3'd2;
    localparam logic [2:0] ST_START = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_LOAD  = 3'd5;

    logic [av6_pkg::CFG_W-1:0]   r_spi;
    logic [av6_pkg::CFG_W-1:0]   r_ic;
    logic [2:0]                  r_state;
    logic [2:0]                  n_state;
    logic [NB-1:0]               r_scnt;
    logic [MB-1:0]               r_icnt;
    logic [av6_pkg::STEP_W-1:0]  r_step;
    logic [2*NB-1:0]             r_nsq;
    logic [D_W-1:0]              r_den;

    logic [NB-1:0]               n_eff;
    logic [MB-1:0]               m_eff;
    logic                        beat;
    logic                        last_s;
    logic                        last_i;
    logic                        free;
    logic                        run_clear;
    av6_pkg::t_lane_ctl          ctl;
    av6_pkg::t_lane_res          lane_res [av6_pkg::AXES];
    logic signed [SAMPLE_BITS-1:0] smp [av6_pkg::AXES];

    always_comb begin
        if (r_spi == '0) begin
            n_eff = NB'(1);
        end else if (32'(r_spi) > MAX_SAMPLES_PER_INTERVAL) begin
            n_eff = NB'(MAX_SAMPLES_PER_INTERVAL);
        end else begin
            n_eff = NB'(r_spi);
        end
        if (r_ic < av6_pkg::CFG_W'(2)) begin
            m_eff = MB'(2);
        end else if (32'(r_ic) > MAX_INTERVALS) begin
            m_eff = MB'(MAX_INTERVALS);
        end else begin
            m_eff = MB'(r_ic);
        end
    end

    assign i_smp.ready = (r_state == ST_IDLE);
    assign beat        = i_smp.valid && i_smp.ready;
    assign last_s      = ({1'b0, r_scnt} + (NB+1)'(1)) >= {1'b0, n_eff};
    assign last_i      = ({1'b0, r_icnt} + (MB+1)'(1)) >= {1'b0, m_eff};
    assign run_clear   = i_cfg_we || (r_state == ST_LOAD && free);

    assign smp[0] = i_smp.accel_x;
    assign smp[1] = i_smp.accel_y;
    assign smp[2] = i_smp.accel_z;
    assign smp[3] = i_smp.gyro_x;
    assign smp[4] = i_smp.gyro_y;
    assign smp[5] = i_smp.gyro_z;

    always_comb begin
        ctl.clear     = run_clear;
        ctl.add       = beat;
        ctl.close     = last_s;
        ctl.first     = (r_icnt == '0);
        ctl.div_start = (r_state == ST_START);
        ctl.div_step  = (r_state == ST_DIV);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (beat && last_s && last_i) begin
                    n_state = ST_MUL1;
                end
            end
            ST_MUL1:  n_state = ST_MUL2;
            ST_MUL2:  n_state = ST_START;
            ST_START: n_state = ST_DIV;
            ST_DIV: begin
                if (r_step == av6_pkg::STEP_W'(av6_pkg::NUM_W - 1)) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spi   <= av6_pkg::SAMPLES_RESET;
            r_ic    <= av6_pkg::INTERVALS_RESET;
            r_state <= ST_IDLE;
            r_scnt  <= '0;
            r_icnt  <= '0;
            r_step  <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    av6_pkg::REG_SAMPLES:   r_spi <= i_cfg_data;
                    av6_pkg::REG_INTERVALS: r_ic  <= i_cfg_data;
                    default: ;
                endcase
            end
            r_state <= i_cfg_we ? ST_IDLE : n_state;
            if (run_clear) begin
                r_scnt <= '0;
                r_icnt <= '0;
            end else if (beat) begin
                if (last_s) begin
                    r_scnt <= '0;
                    r_icnt <= r_icnt + MB'(1);
                end else begin
                    r_scnt <= r_scnt + NB'(1);
                end
            end
            r_step <= (r_state == ST_DIV) ? r_step + av6_pkg::STEP_W'(1) : '0;
        end
    end

    // denominator 2 * n^2 * (m - 1), built over two registered multiplies
    always_ff @(posedge i_clk) begin
        if (r_state == ST_MUL1) begin
            r_nsq <= n_eff * n_eff;
        end
        if (r_state == ST_MUL2) begin
            r_den <= {(D_W-1)'(r_nsq) * (D_W-1)'(m_eff - MB'(1)), 1'b0};
        end
    end

    for (genvar a = 0; a < av6_pkg::AXES; a++) begin : g_lane
        av6_lane #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .SUM_W       (SUM_W),
            .D_W         (D_W)
        ) u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (ctl),
            .i_sample (smp[a]),
            .i_den    (r_den),
            .o_res    (lane_res[a])
        );
    end

    av6_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (r_state == ST_LOAD),
        .i_lane  (lane_res),
        .o_free  (free),
        .o_res   (o_res)
    );

endmodule

// ===== design/av6_chk.sv =====
// port-level checks of allan_variance_six_axis, bound to the top level
// depends on allan_variance_six_axis_assert.svh
`timescale 1ns / 1ps
`include "allan_variance_six_axis_assert.svh"

module av6_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_out_sat
);

    // a result never appears right behind a sample beat: the divider sits between
    `AV6_NEXT(a_no_result_after_beat, i_in_valid && i_in_ready, !$rose(i_out_valid))
    `AV6_NEXT_ALWAYS(a_reset_empties, !i_rst_n, !i_out_valid)
    `AV6_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid)
    `AV6_NEXT(a_sat_hold, i_out_valid && !i_out_ready, $stable(i_out_sat))

endmodule

bind allan_variance_six_axis av6_chk u_av6_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_smp.valid),
    .i_in_ready  (i_smp.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_sat   (o_res.saturated)
);

// ===== dv/tb_top.sv =====
// self-checking testbench of the six-axis allan variance block
// needs av6_pkg, the av6 handshake interfaces and allan_variance_six_axis
`timescale 1ns / 1ps

module tb_top;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 100;
    localparam int HOLD_CYCLES    = 400;
    localparam int ITEM_TARGET    = 750;
    localparam longint unsigned U64_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [av6_pkg::VAR_W-1:0] VAR_MAX = {av6_pkg::VAR_W{1'b1}};
    localparam logic [av6_pkg::VAR_W-1:0] VAR_EXTREME =
        av6_pkg::VAR_W'(64'd65535 * 64'd65535 * 64'd32768);

    typedef struct packed {
        logic [av6_pkg::AXES-1:0][av6_pkg::VAR_W-1:0] var_axis;
        logic                                         sat;
    } t_variance;

    typedef struct packed {
        logic [av6_pkg::AXES-1:0][15:0] smp;
        logic                           known;
        logic [av6_pkg::VAR_W-1:0]      var_all;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [av6_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [av6_pkg::CFG_W-1:0] i_cfg_data;

    av6_smp_if #(.W(16)) smp ();
    av6_res_if res ();

    allan_variance_six_axis i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_smp      (smp.sink),
        .o_res      (res.source)
    );

    // predictor state
    logic [av6_pkg::CFG_W-1:0] cfg_samples;
    logic [av6_pkg::CFG_W-1:0] cfg_intervals;
    longint           sum_cur [av6_pkg::AXES];
    longint           sum_prev [av6_pkg::AXES];
    longint unsigned  sq_acc [av6_pkg::AXES];
    int unsigned      smp_cnt;
    int unsigned      ivl_cnt;
    bit               sat_flag;

    t_variance variance_q[$];
    int  mismatches;
    int  idle_cycles;
    bit  hold_req;
    int  hold_cnt;
    int  burst_left;
    int  sent_items;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic void clear_run();
        for (int a = 0; a < av6_pkg::AXES; a++) begin
            sum_cur[a] = 0;
            sum_prev[a] = 0;
            sq_acc[a] = 0;
        end
        smp_cnt = 0;
        ivl_cnt = 0;
        sat_flag = 0;
    endfunction

    function automatic logic [av6_pkg::VAR_W-1:0] scaled_div(longint unsigned s,
                                                             longint unsigned d);
        longint unsigned qi;
        longint unsigned r;
        logic [79:0]     frac;
        qi = s / d;
        r = s % d;
        if (qi > 64'hFFFF_FFFF) begin
            sat_flag = 1;
            return VAR_MAX;
        end
        frac = ({16'd0, r} << 16) / {16'd0, d};
        return av6_pkg::VAR_W'((qi << 16) + frac[63:0]);
    endfunction

    // one sample through the predictor; returns 1 when a run closes
    function automatic bit predict_sample(logic [av6_pkg::AXES-1:0][15:0] s,
                                          output t_variance v);
        longint unsigned n, m, mag, sq, d;
        n = (cfg_samples < 1) ? 1 : (cfg_samples > 1024) ? 1024 : cfg_samples;
        m = (cfg_intervals < 2) ? 2 : (cfg_intervals > 1024) ? 1024 : cfg_intervals;
        v = '0;
        for (int a = 0; a < av6_pkg::AXES; a++) sum_cur[a] += longint'($signed(s[a]));
        smp_cnt++;
        if (smp_cnt < n) return 0;
        for (int a = 0; a < av6_pkg::AXES; a++) begin
            if (ivl_cnt != 0) begin
                mag = (sum_cur[a] >= sum_prev[a]) ? sum_cur[a] - sum_prev[a]
                                                   : sum_prev[a] - sum_cur[a];
                if (mag > 64'hFFFF_FFFF) begin
                    sq = U64_MAX;
                    sat_flag = 1;
                end else begin
                    sq = mag * mag;
                end
                if (sq_acc[a] > U64_MAX - sq) begin
                    sq_acc[a] = U64_MAX;
                    sat_flag = 1;
                end else begin
                    sq_acc[a] += sq;
                end
            end
            sum_prev[a] = sum_cur[a];
            sum_cur[a] = 0;
        end
        smp_cnt = 0;
        ivl_cnt++;
        if (ivl_cnt < m) return 0;
        d = 2 * n * n * (m - 1);
        for (int a = 0; a < av6_pkg::AXES; a++) v.var_axis[a] = scaled_div(sq_acc[a], d);
        v.sat = sat_flag;
        clear_run();
        return 1;
    endfunction

    // drives one write beat; the caller drops the write enable afterwards
    task automatic write_reg(logic [av6_pkg::CFG_IDX_W-1:0] idx,
                             logic [av6_pkg::CFG_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        if (idx == av6_pkg::REG_SAMPLES) cfg_samples = val;
        else cfg_intervals = val;
        clear_run();
    endtask

    task automatic drain_results();
        smp.valid <= 1'b0;
        do @(posedge i_clk); while (variance_q.size() != 0);
    endtask

    task automatic set_config(logic [av6_pkg::CFG_W-1:0] n_val,
                              logic [av6_pkg::CFG_W-1:0] m_val);
        drain_results();
        // a partial run may still be settling inside the block
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        write_reg(av6_pkg::REG_SAMPLES, n_val);
        write_reg(av6_pkg::REG_INTERVALS, m_val);
        i_cfg_we <= 1'b0;
    endtask

    // sends one sample beat; known results replace the predicted value
    task automatic send_sample(logic [av6_pkg::AXES-1:0][15:0] s, bit known,
                               logic [av6_pkg::VAR_W-1:0] kv);
        t_variance v;
        int        gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 12);
            if (gap > 0) begin
                smp.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        smp.valid   <= 1'b1;
        smp.accel_x <= s[0];
        smp.accel_y <= s[1];
        smp.accel_z <= s[2];
        smp.gyro_x  <= s[3];
        smp.gyro_y  <= s[4];
        smp.gyro_z  <= s[5];
        do @(posedge i_clk); while (!smp.ready);
        sent_items++;
        if (predict_sample(s, v)) begin
            if (known) begin
                for (int a = 0; a < av6_pkg::AXES; a++) v.var_axis[a] = kv;
                v.sat = 1'b0;
            end
            variance_q = {variance_q, v};
        end
    endtask

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'($urandom_range(0, 15)) - 16'd8;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic run_phase(logic [av6_pkg::CFG_W-1:0] n_val,
                             logic [av6_pkg::CFG_W-1:0] m_val,
                             int items, bit with_hold);
        logic [av6_pkg::AXES-1:0][15:0] s;
        logic [av6_pkg::AXES-1:0][15:0] bias;
        set_config(n_val, m_val);
        for (int a = 0; a < av6_pkg::AXES; a++) bias[a] = rand_sample();
        for (int i = 0; i < items; i++) begin
            if (with_hold && i == 2) hold_req = 1;
            // mid-phase pause until the block has delivered everything
            if (with_hold && i == items / 2) drain_results();
            for (int a = 0; a < av6_pkg::AXES; a++)
                s[a] = ($urandom_range(0, 3) == 0) ? rand_sample()
                                                   : bias[a] + 16'($urandom_range(0, 63));
            send_sample(s, 1'b0, '0);
        end
    endtask

    // result checker and receiver stall pattern
    initial begin
        int mode;
        t_variance got, want;
        res.ready <= 1'b0;
        mode = 0;
        hold_cnt = 0;
        forever begin
            @(posedge i_clk);
            if (res.valid && res.ready) begin
                got.var_axis[0] = res.accel_x_variance;
                got.var_axis[1] = res.accel_y_variance;
                got.var_axis[2] = res.accel_z_variance;
                got.var_axis[3] = res.gyro_x_variance;
                got.var_axis[4] = res.gyro_y_variance;
                got.var_axis[5] = res.gyro_z_variance;
                got.sat = res.saturated;
                if (variance_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result beat %h", got);
                end else begin
                    want = variance_q.pop_front();
                    for (int a = 0; a <= av6_pkg::AXES; a++) begin
                        if ((a < av6_pkg::AXES && got.var_axis[a] !== want.var_axis[a]) ||
                            (a == av6_pkg::AXES && got.sat !== want.sat)) begin
                            mismatches++;
                            if (mismatches <= 10)
                                $display("field %0d: expected %h got %h", a,
                                         (a < av6_pkg::AXES) ? want.var_axis[a]
                                                             : 48'(want.sat),
                                         (a < av6_pkg::AXES) ? got.var_axis[a]
                                                             : 48'(got.sat));
                        end
                    end
                end
            end
            if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
            if (hold_cnt > 0) begin
                hold_cnt--;
                res.ready <= 1'b0;
            end else if (hold_req) begin
                hold_req = 0;
                hold_cnt = HOLD_CYCLES;
                res.ready <= 1'b0;
            end else begin
                case (mode)
                    0: res.ready <= 1'b1;
                    1: res.ready <= 1'($urandom_range(0, 1));
                    default: res.ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // watchdog on cycles with no beat and no register write
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((smp.valid && smp.ready) || (res.valid && res.ready) || i_cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_top failed");
                $finish;
            end
        end
    end

    initial begin
        t_stim_row rows[12];
        int items;
        logic [av6_pkg::CFG_W-1:0] n_val, m_val;
        rows[0]  = '{smp: {6{16'h0000}}, known: 0, var_all: '0};
        rows[1]  = '{smp: {6{16'h0000}}, known: 1, var_all: '0};
        rows[2]  = '{smp: {6{16'h7FFF}}, known: 0, var_all: '0};
        rows[3]  = '{smp: {6{16'h8000}}, known: 1, var_all: VAR_EXTREME};
        rows[4]  = '{smp: {6{16'h8000}}, known: 0, var_all: '0};
        rows[5]  = '{smp: {6{16'h7FFF}}, known: 1, var_all: VAR_EXTREME};
        rows[6]  = '{smp: {16'h7FFF, 16'h8000, 16'h0000, 16'h0001, 16'hFFFF, 16'h3039},
                     known: 0, var_all: '0};
        rows[7]  = '{smp: {16'hFFFF, 16'h0000, 16'h7FFF, 16'h8000, 16'h0001, 16'hCFC7},
                     known: 0, var_all: '0};
        rows[8]  = '{smp: {6{16'h5555}}, known: 0, var_all: '0};
        rows[9]  = '{smp: {6{16'hAAAA}}, known: 0, var_all: '0};
        rows[10] = '{smp: {6{16'h0007}}, known: 0, var_all: '0};
        rows[11] = '{smp: {6{16'h0007}}, known: 1, var_all: '0};

        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= av6_pkg::REG_SAMPLES;
        i_cfg_data <= '0;
        smp.valid  <= 1'b0;
        smp.accel_x <= '0;
        smp.accel_y <= '0;
        smp.accel_z <= '0;
        smp.gyro_x <= '0;
        smp.gyro_y <= '0;
        smp.gyro_z <= '0;
        mismatches = 0;
        hold_req = 0;
        burst_left = 0;
        sent_items = 0;
        cfg_samples = av6_pkg::SAMPLES_RESET;
        cfg_intervals = av6_pkg::INTERVALS_RESET;
        clear_run();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings, a partial run that the write below abandons
        for (int i = 0; i < 30; i++) send_sample({6{rand_sample()}}, 1'b0, '0);

        // one-sample intervals, pairs of rows give one result each
        set_config(11'd1, 11'd2);
        foreach (rows[i]) send_sample(rows[i].smp, rows[i].known, rows[i].var_all);

        // clamped and extreme settings
        run_phase(11'd0, 11'd1, 8, 1'b0);
        run_phase(11'd1, 11'd2047, 40, 1'b0);
        run_phase(11'd2047, 11'd0, 40, 1'b0);
        run_phase(11'd1024, 11'd2, 40, 1'b0);
        run_phase(11'd3, 11'd4, 60, 1'b1);

        while (sent_items < ITEM_TARGET) begin
            n_val = 11'($urandom_range(1, 4));
            m_val = 11'($urandom_range(2, 6));
            // whole runs plus a ragged tail that the next write cuts off
            items = int'(n_val) * int'(m_val) * int'($urandom_range(1, 4))
                    + int'($urandom_range(0, int'(n_val) * int'(m_val) - 1));
            run_phase(n_val, m_val, items, 1'b0);
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && variance_q.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
